/* hdl/gopd_pkg.sv */
// Shared types and constants for the glyph outline point decoder.
`default_nettype none
package gopd_pkg;

  localparam int PtsW   = 6;   // point count width
  localparam int IdxW   = 5;   // point index width
  localparam int CoordW = 17;  // emitted coordinate width
  localparam int FlagW  = 5;   // packed flag: on, xshort, yshort, xinfo, yinfo
  localparam int SumW   = 16;  // running coordinate width

  // Raw flag byte bit that announces a repeat-count byte
  localparam int FlagRepeatBit = 3;

  // Packed flag bit positions
  localparam int PkOn     = 0;
  localparam int PkXShort = 1;
  localparam int PkYShort = 2;
  localparam int PkXInfo  = 3;
  localparam int PkYInfo  = 4;

  typedef enum logic {
    ITEM_BYTE  = 1'b0,
    ITEM_START = 1'b1
  } item_kind_e;

  // Request passed from front to back
  typedef struct packed {
    item_kind_e  kind;
    logic [7:0]  data;
  } q_item_t;

  // Per-glyph constants held by the front
  typedef struct packed {
    logic [PtsW-1:0]        pts;
    logic signed [SumW-1:0] x_org;
    logic signed [SumW-1:0] y_org;
  } glyph_info_t;

endpackage
`default_nettype wire

/* hdl/gopd_if.sv */
// Valid/ready channel interfaces for byte input and coordinate output.
`default_nettype none
interface gopd_in_if import gopd_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [7:0]             data_byte;
  logic                   glyph_start;
  logic [PtsW-1:0]        point_total;
  logic signed [SumW-1:0] box_x_min;
  logic signed [SumW-1:0] box_y_min;

  modport source (output valid, data_byte, glyph_start, point_total, box_x_min, box_y_min,
                  input ready);
  modport sink   (input valid, data_byte, glyph_start, point_total, box_x_min, box_y_min,
                  output ready);
endinterface

interface gopd_out_if import gopd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     axis;
  logic [IdxW-1:0]          point_index;
  logic signed [CoordW-1:0] coordinate;
  logic                     on_curve;
  logic                     last;

  modport source (output valid, axis, point_index, coordinate, on_curve, last,
                  input ready);
  modport sink   (input valid, axis, point_index, coordinate, on_curve, last,
                  output ready);
endinterface
`default_nettype wire

/* hdl/gopd_front.sv */
// Front end: accepts bytes, expands flags into the flag store, forwards coordinate bytes.
`default_nettype none
module gopd_front import gopd_pkg::*; #(
  parameter  int MaxPoints = 32,
  localparam int AddrW     = (MaxPoints > 1) ? $clog2(MaxPoints) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  gopd_in_if.sink               in_i,
  output q_item_t               push_item_o,
  output logic                  push_valid_o,
  input  wire logic             q_full_i,
  input  wire logic             q_empty_i,
  input  wire logic             back_busy_i,
  input  wire logic [AddrW-1:0] rd_idx_i,
  output logic [FlagW-1:0]      rd_flag_o,
  output glyph_info_t           info_o
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_FLAG,
    PH_REPEAT,
    PH_COORD
  } phase_e;

  phase_e          phase_q, phase_d, phase_eff;
  logic [PtsW-1:0] cnt_q, cnt_d, cnt_base, pts_eff, pt_sat, new_cnt;
  logic [7:0]      last_q, last_d, pf;
  glyph_info_t     info_q, info_d;
  logic [FlagW-1:0] store_q [MaxPoints];
  logic            acc, gs, wr;
  logic [8:0]      n, sum;
  logic [FlagW-1:0] packed_flag;

  // A new glyph waits until the back end has used up the old one
  assign gs          = in_i.glyph_start;
  assign in_i.ready  = !q_full_i && (!gs || (q_empty_i && !back_busy_i));
  assign acc         = in_i.valid && in_i.ready;
  assign pt_sat      = (in_i.point_total > PtsW'(MaxPoints)) ? PtsW'(MaxPoints)
                                                               : in_i.point_total;
  assign phase_eff   = gs ? PH_FLAG : phase_q;
  assign cnt_base    = gs ? '0 : cnt_q;
  assign pts_eff     = gs ? pt_sat : info_q.pts;
  assign sum         = 9'(cnt_base) + n;
  assign new_cnt     = (sum >= 9'(pts_eff)) ? pts_eff : sum[PtsW-1:0];
  assign packed_flag = {pf[5], pf[4], pf[2:0]};

  assign rd_flag_o = store_q[rd_idx_i];
  assign info_o    = info_q;

  // Byte classification
  always_comb begin
    phase_d      = phase_q;
    cnt_d        = cnt_q;
    last_d       = last_q;
    info_d       = info_q;
    wr           = 1'b0;
    n            = 9'd1;
    pf           = in_i.data_byte;
    push_valid_o = 1'b0;
    push_item_o  = '{kind: ITEM_BYTE, data: in_i.data_byte};
    if (acc) begin
      if (gs) begin
        info_d = '{pts: pt_sat, x_org: in_i.box_x_min, y_org: in_i.box_y_min};
        cnt_d  = '0;
        last_d = '0;
      end
      if (gs && pt_sat == '0) begin
        phase_d = PH_IDLE;
      end else begin
        unique case (phase_eff)
          PH_FLAG: begin
            if (in_i.data_byte[FlagRepeatBit]) begin
              last_d  = in_i.data_byte;
              phase_d = PH_REPEAT;
            end else begin
              wr = 1'b1;
            end
          end
          PH_REPEAT: begin
            wr = 1'b1;
            n  = 9'd1 + 9'(in_i.data_byte);
            pf = last_q;
          end
          PH_COORD: begin
            push_valid_o = 1'b1;
          end
          PH_IDLE: begin
          end
          default: phase_d = PH_IDLE;
        endcase
        if (wr) begin
          cnt_d = new_cnt;
          if (new_cnt >= pts_eff) begin
            push_valid_o = 1'b1;
            push_item_o  = '{kind: ITEM_START, data: in_i.data_byte};
            phase_d      = PH_COORD;
          end else begin
            phase_d = PH_FLAG;
          end
        end
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      last_q  <= '0;
      info_q  <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      last_q  <= last_d;
      info_q  <= info_d;
    end
  end

  // Flag store: a repeat run fills a range of entries at once
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MaxPoints; k++) begin
      if (acc && wr && PtsW'(k) >= cnt_base && PtsW'(k) < new_cnt) begin
        store_q[k] <= packed_flag;
      end
    end
  end

endmodule
`default_nettype wire

/* hdl/gopd_queue.sv */
// Two-entry queue between front and back.
`default_nettype none
module gopd_queue import gopd_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  q_item_t      push_item_i,
  input  wire logic    pop_i,
  output q_item_t      head_o,
  output logic         valid_o,
  output logic         full_o,
  output logic         empty_o
);

  q_item_t    mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign head_o  = mem_q[rp_q];
  assign empty_o = (cnt_q == 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = !empty_o;

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= !wp_q;
      if (pop_i)  rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  // Entries
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= push_item_i;
  end

endmodule
`default_nettype wire

/* hdl/gopd_back.sv */
// Back end: decodes coordinate deltas and emits coordinates, holding while the output slot is full.
`default_nettype none
module gopd_back import gopd_pkg::*; #(
  parameter  int MaxPoints = 32,
  localparam int AddrW     = (MaxPoints > 1) ? $clog2(MaxPoints) : 1
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  q_item_t           item_i,
  input  wire logic         item_valid_i,
  output logic              pop_o,
  output logic              busy_o,
  output logic [AddrW-1:0]  rd_idx_o,
  input  wire logic [FlagW-1:0] flag_i,
  input  glyph_info_t       info_i,
  gopd_out_if.source        out_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WAIT,
    ST_DRAIN
  } state_e;

  state_e              state_q, state_d;
  logic                axis_q, axis_d;
  logic [PtsW-1:0]     cur_q, cur_d;
  logic [SumW-1:0]     run_q, run_d, run_e;
  logic                pv_q, pv_d;
  logic [7:0]          ph_q, ph_d;
  logic                ov_q, slot_free, emit, dlt_short, is_info, at_end;
  logic                o_axis_q, o_on_q, o_last_q;
  logic [IdxW-1:0]     o_idx_q;
  logic signed [CoordW-1:0] o_coord_q, coord;
  logic signed [SumW-1:0]   org;

  assign rd_idx_o  = cur_q[AddrW-1:0];
  assign busy_o    = (state_q == ST_DRAIN);
  assign slot_free = !ov_q || out_o.ready;
  assign pop_o     = item_valid_i && slot_free && (state_q != ST_DRAIN);
  assign dlt_short = axis_q ? flag_i[PkYShort] : flag_i[PkXShort];
  assign is_info   = axis_q ? flag_i[PkYInfo]  : flag_i[PkXInfo];
  assign at_end    = (7'(cur_q) + 7'd1) >= 7'(info_i.pts);
  assign org       = axis_q ? info_i.y_org : info_i.x_org;
  assign coord     = CoordW'(signed'(run_e)) - CoordW'(org);

  // Delta decode and point advance
  always_comb begin
    state_d = state_q;
    axis_d  = axis_q;
    cur_d   = cur_q;
    run_d   = run_q;
    pv_d    = pv_q;
    ph_d    = ph_q;
    run_e   = run_q;
    emit    = 1'b0;
    if (pop_o) begin
      if (item_i.kind == ITEM_START) begin
        axis_d  = 1'b0;
        cur_d   = '0;
        run_d   = '0;
        pv_d    = 1'b0;
        state_d = ST_DRAIN;
      end else if (state_q == ST_WAIT) begin
        if (dlt_short) begin
          run_e = is_info ? run_q + SumW'(item_i.data) : run_q - SumW'(item_i.data);
          emit  = 1'b1;
        end else if (pv_q) begin
          run_e = run_q + {ph_q, item_i.data};
          pv_d  = 1'b0;
          emit  = 1'b1;
        end else begin
          pv_d = 1'b1;
          ph_d = item_i.data;
        end
      end
    end else if (state_q == ST_DRAIN) begin
      // Points that repeat the previous value take no byte
      if (!dlt_short && is_info) begin
        emit = slot_free;
      end else begin
        state_d = ST_WAIT;
      end
    end
    if (emit) begin
      run_d = run_e;
      if (at_end) begin
        if (!axis_q) begin
          axis_d  = 1'b1;
          cur_d   = '0;
          run_d   = '0;
          pv_d    = 1'b0;
          state_d = ST_DRAIN;
        end else begin
          state_d = ST_IDLE;
        end
      end else begin
        cur_d   = cur_q + 1'b1;
        state_d = ST_DRAIN;
      end
    end
  end

  // State and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      axis_q    <= 1'b0;
      cur_q     <= '0;
      run_q     <= '0;
      pv_q      <= 1'b0;
      ph_q      <= '0;
      ov_q      <= 1'b0;
      o_axis_q  <= 1'b0;
      o_idx_q   <= '0;
      o_coord_q <= '0;
      o_on_q    <= 1'b0;
      o_last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
      cur_q   <= cur_d;
      run_q   <= run_d;
      pv_q    <= pv_d;
      ph_q    <= ph_d;
      if (emit) begin
        ov_q      <= 1'b1;
        o_axis_q  <= axis_q;
        o_idx_q   <= cur_q[IdxW-1:0];
        o_coord_q <= coord;
        o_on_q    <= flag_i[PkOn];
        o_last_q  <= axis_q && at_end;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  assign out_o.valid       = ov_q;
  assign out_o.axis        = o_axis_q;
  assign out_o.point_index = o_idx_q;
  assign out_o.coordinate  = o_coord_q;
  assign out_o.on_curve    = o_on_q;
  assign out_o.last        = o_last_q;

endmodule
`default_nettype wire

/* hdl/glyph_outline_point_decoder.sv */
// Path: an accepted coordinate byte passes through the queue and then the output register.
// Throughput: flag bytes one per cycle; after a byte that completes a coordinate the back
// end drains before taking the next byte; byte-less points emit one per cycle while the output slot is free.
// A new glyph start waits until the queue is empty and the back end has drained.
// Reset (rst_ni low, asynchronous) returns both ends to idle; flag store is not cleared.
`default_nettype none
module glyph_outline_point_decoder import gopd_pkg::*; #(
  parameter int MaxPoints = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  gopd_in_if.sink   in_i,
  gopd_out_if.source out_o
);

  localparam int AddrW = (MaxPoints > 1) ? $clog2(MaxPoints) : 1;

  q_item_t          push_item, head;
  logic             push_valid, q_full, q_empty, q_valid, pop, back_busy;
  logic [AddrW-1:0] rd_idx;
  logic [FlagW-1:0] rd_flag;
  glyph_info_t      info;

  gopd_front #(.MaxPoints(MaxPoints)) u_front (
    .clk_i, .rst_ni, .in_i,
    .push_item_o (push_item),
    .push_valid_o(push_valid),
    .q_full_i    (q_full),
    .q_empty_i   (q_empty),
    .back_busy_i (back_busy),
    .rd_idx_i    (rd_idx),
    .rd_flag_o   (rd_flag),
    .info_o      (info)
  );

  gopd_queue u_queue (
    .clk_i, .rst_ni,
    .push_i     (push_valid),
    .push_item_i(push_item),
    .pop_i      (pop),
    .head_o     (head),
    .valid_o    (q_valid),
    .full_o     (q_full),
    .empty_o    (q_empty)
  );

  gopd_back #(.MaxPoints(MaxPoints)) u_back (
    .clk_i, .rst_ni,
    .item_i      (head),
    .item_valid_i(q_valid),
    .pop_o       (pop),
    .busy_o      (back_busy),
    .rd_idx_o    (rd_idx),
    .flag_i      (rd_flag),
    .info_i      (info),
    .out_o
  );

endmodule
`default_nettype wire
